### sv/dfr_pkg.sv
// dfr_pkg: shared constants, types, microcode table and lookup functions
`default_nettype none

package dfr_pkg;

  // sizing
  localparam int MAX_THETA    = 4;
  localparam int MAX_DIM      = 64;
  localparam int SAMPLE_WIDTH = 16;

  localparam int WIN_MAX    = 2 * MAX_THETA + 1;
  localparam int THETA_W    = $clog2(MAX_THETA + 1);
  localparam int WIN_W      = $clog2(WIN_MAX + 1);
  localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_CNT_W  = $clog2(MAX_DIM + 1);
  localparam int ADDR_W     = WIN_W + IDX_W;
  localparam int RING_DEPTH = WIN_MAX * (2 ** IDX_W);

  // arithmetic widths
  localparam int SUM_K     = MAX_THETA * (MAX_THETA + 1) / 2;
  localparam int ACC_W     = SAMPLE_WIDTH + 1 + $clog2(SUM_K + 1);
  localparam int FRAC_BITS = 18;
  localparam int RECIP_W   = FRAC_BITS;
  localparam int PROD_W    = ACC_W + RECIP_W + 1;

  // configuration registers
  localparam int THETA_REG_W = 3;
  localparam int DIM_REG_W   = 7;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_ADDR_W  = 1;
  localparam logic [THETA_REG_W-1:0] THETA_RESET = 3'd2;
  localparam logic [DIM_REG_W-1:0]   DIM_RESET   = 7'd39;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_THETA     = 1'b0,
    REG_FRAME_DIM = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_FLUSH  = 1'b1
  } op_e;

  // channel payloads
  typedef struct packed {
    logic                           op;
    logic signed [SAMPLE_WIDTH-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] delta_value;
    logic [IDX_W-1:0]               dim_index;
    logic                           frame_end;
    logic                           stream_end;
  } out_item_t;

  // microprogram steps
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_ISSUE = 3'd1,
    ST_ACC   = 3'd2,
    ST_MUL   = 3'd3,
    ST_OUT   = 3'd4
  } step_e;

  // jump conditions
  typedef enum logic [1:0] {
    JMP_NEXT  = 2'd0,
    JMP_EMIT  = 2'd1,
    JMP_LOOP  = 2'd2,
    JMP_DRAIN = 2'd3
  } jump_e;

  typedef struct packed {
    logic  accept;
    logic  issue;
    logic  acc;
    logic  mul;
    logic  load;
    jump_e jump;
    step_e target;
  } ucode_t;

  // control from the sequencer to the datapath and the output register
  typedef struct packed {
    logic               accept;
    logic               issue;
    logic               acc;
    logic               mul;
    logic               load;
    logic [THETA_W-1:0] k;
  } ctl_t;

  // microcode rom
  function automatic ucode_t ucode_rom(input step_e s);
    ucode_t w;
    w        = '0;
    w.jump   = JMP_NEXT;
    w.target = ST_IDLE;
    case (s)
      ST_IDLE: begin
        w.accept = 1'b1;
        w.jump   = JMP_EMIT;
        w.target = ST_ISSUE;
      end
      ST_ISSUE: begin
        w.issue = 1'b1;
      end
      ST_ACC: begin
        w.acc    = 1'b1;
        w.jump   = JMP_LOOP;
        w.target = ST_ISSUE;
      end
      ST_MUL: begin
        w.mul = 1'b1;
      end
      ST_OUT: begin
        w.load   = 1'b1;
        w.jump   = JMP_DRAIN;
        w.target = ST_IDLE;
      end
      default: begin
        w.jump   = JMP_DRAIN;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  // round(2^18 / (2 * sum k^2)) for each window half width
  function automatic logic [RECIP_W-1:0] recip_lut(input int unsigned th);
    logic [RECIP_W-1:0] r;
    case (th)
      1:       r = RECIP_W'(131072);
      2:       r = RECIP_W'(26214);
      3:       r = RECIP_W'(9362);
      4:       r = RECIP_W'(4369);
      5:       r = RECIP_W'(2383);
      6:       r = RECIP_W'(1440);
      7:       r = RECIP_W'(936);
      8:       r = RECIP_W'(643);
      default: r = RECIP_W'(131072);
    endcase
    return r;
  endfunction

  // ring slot that lies back frames behind newest
  function automatic logic [WIN_W-1:0] ring_slot(input logic [WIN_W-1:0] newest,
                                                 input logic [WIN_W-1:0] back,
                                                 input logic [WIN_W-1:0] w);
    logic [WIN_W-1:0] s;
    if (newest >= back) begin
      s = newest - back;
    end else begin
      s = newest + w - back;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### sv/dfr_ram.sv
// dfr_ram: generic one-write two-read ram with registered read data
`default_nettype none

module dfr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 576,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // write port and both read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

### sv/dfr_seq.sv
// dfr_seq: microcode sequencer with step counter and tap counter
`default_nettype none

module dfr_seq (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [dfr_pkg::THETA_W-1:0] th_i,
  input  wire logic                        go_i,
  input  wire logic                        drain_ok_i,
  output dfr_pkg::ctl_t                    ctl_o
);

  dfr_pkg::step_e                upc_q, upc_d;
  logic [dfr_pkg::THETA_W-1:0]   k_q, k_d;
  dfr_pkg::ucode_t               word;

  assign word = dfr_pkg::ucode_rom(upc_q);

  // next step and tap index
  always_comb begin
    upc_d = upc_q;
    k_d   = k_q;
    case (word.jump)
      dfr_pkg::JMP_NEXT: begin
        upc_d = dfr_pkg::step_e'(upc_q + 3'd1);
      end
      dfr_pkg::JMP_EMIT: begin
        if (go_i) begin
          upc_d = word.target;
          k_d   = dfr_pkg::THETA_W'(1);
        end
      end
      dfr_pkg::JMP_LOOP: begin
        if (k_q != th_i) begin
          upc_d = word.target;
          k_d   = k_q + dfr_pkg::THETA_W'(1);
        end else begin
          upc_d = dfr_pkg::step_e'(upc_q + 3'd1);
        end
      end
      dfr_pkg::JMP_DRAIN: begin
        if (drain_ok_i) begin
          upc_d = word.target;
        end
      end
      default: begin
        upc_d = dfr_pkg::ST_IDLE;
      end
    endcase
  end

  // control word to the datapath
  always_comb begin
    ctl_o.accept = word.accept;
    ctl_o.issue  = word.issue;
    ctl_o.acc    = word.acc;
    ctl_o.mul    = word.mul;
    ctl_o.load   = word.load & drain_ok_i;
    ctl_o.k      = k_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= dfr_pkg::ST_IDLE;
      k_q   <= dfr_pkg::THETA_W'(1);
    end else begin
      upc_q <= upc_d;
      k_q   <= k_d;
    end
  end

endmodule

`default_nettype wire

### sv/dfr_dp.sv
// dfr_dp: tap addressing, weighted difference accumulator, scaling and saturation
`default_nettype none

module dfr_dp (
  input  wire logic                                   clk_i,
  input  wire dfr_pkg::ctl_t                          ctl_i,
  input  wire logic [dfr_pkg::THETA_W-1:0]            th_i,
  input  wire logic [dfr_pkg::WIN_W-1:0]              win_i,
  input  wire logic [dfr_pkg::WIN_W-1:0]              newest_i,
  input  wire logic [dfr_pkg::WIN_W-1:0]              avail_i,
  input  wire logic [dfr_pkg::THETA_W-1:0]            lag_i,
  input  wire logic [dfr_pkg::IDX_W-1:0]              idx_i,
  input  wire logic signed [dfr_pkg::SAMPLE_WIDTH-1:0] rd_fwd_i,
  input  wire logic signed [dfr_pkg::SAMPLE_WIDTH-1:0] rd_bwd_i,
  output logic      [dfr_pkg::ADDR_W-1:0]             addr_fwd_o,
  output logic      [dfr_pkg::ADDR_W-1:0]             addr_bwd_o,
  output logic                                        re_o,
  output logic signed [dfr_pkg::SAMPLE_WIDTH-1:0]     delta_o
);

  localparam int SW     = dfr_pkg::SAMPLE_WIDTH;
  localparam int WW     = dfr_pkg::WIN_W;
  localparam int TERM_W = SW + dfr_pkg::THETA_W + 2;
  localparam int PW     = dfr_pkg::PROD_W;
  localparam logic signed [PW-1:0] HALF   = PW'(1) <<< (dfr_pkg::FRAC_BITS - 1);
  localparam logic signed [PW-1:0] SAT_HI = {{(PW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
  localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;

  logic [WW-1:0]                     k_w;
  logic [WW-1:0]                     lag_w;
  logic [WW-1:0]                     back_fwd;
  logic [WW-1:0]                     back_bwd;
  logic [WW-1:0]                     back_sum;
  logic [WW-1:0]                     back_lim;
  logic signed [SW:0]                diff;
  logic signed [TERM_W-1:0]          term;
  logic signed [dfr_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic signed [dfr_pkg::RECIP_W:0]  recip_s;
  logic signed [PW-1:0]              prod_q, prod_d;
  logic signed [PW-1:0]              rounded;
  logic signed [PW-1:0]              scaled;

  // frames ahead and behind the output frame for tap k, clamped to the stream edges
  always_comb begin
    k_w      = WW'(ctl_i.k);
    lag_w    = WW'(lag_i);
    back_fwd = (lag_w > k_w) ? lag_w - k_w : '0;
    back_sum = lag_w + k_w;
    back_lim = avail_i - WW'(1);
    back_bwd = (back_sum > back_lim) ? back_lim : back_sum;
  end

  assign addr_fwd_o = {dfr_pkg::ring_slot(newest_i, back_fwd, win_i), idx_i};
  assign addr_bwd_o = {dfr_pkg::ring_slot(newest_i, back_bwd, win_i), idx_i};
  assign re_o       = ctl_i.issue;

  // k * (ahead - behind) into the accumulator
  always_comb begin
    diff  = $signed({rd_fwd_i[SW-1], rd_fwd_i}) - $signed({rd_bwd_i[SW-1], rd_bwd_i});
    term  = diff * $signed({1'b0, ctl_i.k});
    acc_d = acc_q;
    if (ctl_i.accept) begin
      acc_d = '0;
    end else if (ctl_i.acc) begin
      acc_d = acc_q + dfr_pkg::ACC_W'(term);
    end
  end

  // scale by the reciprocal of the weight sum
  always_comb begin
    recip_s = $signed({1'b0, dfr_pkg::recip_lut(32'(th_i))});
    prod_d  = acc_q * recip_s;
  end

  // round half up, drop fraction, saturate
  always_comb begin
    rounded = prod_q + HALF;
    scaled  = rounded >>> dfr_pkg::FRAC_BITS;
    if (scaled > SAT_HI) begin
      delta_o = SAT_HI[SW-1:0];
    end else if (scaled < SAT_LO) begin
      delta_o = SAT_LO[SW-1:0];
    end else begin
      delta_o = scaled[SW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (ctl_i.mul) begin
      prod_q <= prod_d;
    end
  end

endmodule

`default_nettype wire

### sv/delta_feature_regression_core.sv
// delta_feature_regression_core: regression deltas over a ring of feature frames
//
//   channel | handshake                       | payload
//   --------+---------------------------------+----------------------------------
//   in      | in_valid_i / in_ready_o         | in_data_i  (op, sample)
//   out     | out_valid_o / out_ready_i       | out_data_o (delta, index, ends)
//   cfg     | cfg_we_i, no wait               | cfg_addr_i, cfg_wdata_i
//
// an item that gives no result is taken in the entry step; one that gives a result
// starts the microprogram, which reads one tap pair from the two ring read
// ports and accumulates it in two steps per tap, then scales and rounds.
// reset restores theta 2, frame size 39 and an empty stream; the ring needs no clearing.
// the next item is taken while a result waits in the output register; a result
// waits in the last step only while the output register is full and not being read.
`default_nettype none

module delta_feature_regression_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire dfr_pkg::in_item_t              in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output dfr_pkg::out_item_t                  out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [dfr_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [dfr_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int WW = dfr_pkg::WIN_W;
  localparam int TW = dfr_pkg::THETA_W;
  localparam int IW = dfr_pkg::IDX_W;

  // configuration
  logic [dfr_pkg::THETA_REG_W-1:0] theta_q, theta_d;
  logic [dfr_pkg::DIM_REG_W-1:0]   dim_q, dim_d;

  // stream state
  logic [WW-1:0] head_q, head_d;
  logic [WW-1:0] seen_q, seen_d;
  logic [IW-1:0] elem_q, elem_d;
  logic [TW-1:0] pend_q, pend_d;
  logic          flush_q, flush_d;

  // per-item context
  logic [WW-1:0] newest_q, newest_d;
  logic [WW-1:0] avail_q, avail_d;
  logic [TW-1:0] lag_q, lag_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          fend_q, fend_d;
  logic          send_q, send_d;

  // output register
  logic               out_valid_q;
  dfr_pkg::out_item_t out_q;

  logic [TW-1:0]                        th;
  logic [WW-1:0]                        win;
  logic [dfr_pkg::DIM_CNT_W-1:0]        dim_eff;
  logic [IW-1:0]                        last_idx;
  logic                                 accept;
  logic                                 emit;
  logic                                 go;
  logic                                 drain_ok;
  logic                                 ram_we;
  logic [dfr_pkg::ADDR_W-1:0]           ram_waddr;
  logic [TW-1:0]                        pend_cur;
  logic [IW-1:0]                        j_cur;
  logic                                 last_cur;
  logic                                 end_cur;
  dfr_pkg::ctl_t                        ctl;
  logic [dfr_pkg::ADDR_W-1:0]           addr_fwd;
  logic [dfr_pkg::ADDR_W-1:0]           addr_bwd;
  logic                                 ram_re;
  logic [dfr_pkg::SAMPLE_WIDTH-1:0]     rd_fwd;
  logic [dfr_pkg::SAMPLE_WIDTH-1:0]     rd_bwd;
  logic signed [dfr_pkg::SAMPLE_WIDTH-1:0] delta;

  // effective window and frame size
  always_comb begin
    if (theta_q == '0) begin
      th = TW'(1);
    end else if (32'(theta_q) > dfr_pkg::MAX_THETA) begin
      th = TW'(dfr_pkg::MAX_THETA);
    end else begin
      th = TW'(theta_q);
    end
    win = WW'({th, 1'b0}) + WW'(1);
    if (dim_q == '0) begin
      dim_eff = dfr_pkg::DIM_CNT_W'(1);
    end else if (32'(dim_q) > dfr_pkg::MAX_DIM) begin
      dim_eff = dfr_pkg::DIM_CNT_W'(dfr_pkg::MAX_DIM);
    end else begin
      dim_eff = dfr_pkg::DIM_CNT_W'(dim_q);
    end
    last_idx = IW'(dim_eff - dfr_pkg::DIM_CNT_W'(1));
  end

  assign in_ready_o = ctl.accept;
  assign accept     = in_valid_i & in_ready_o;
  assign go         = accept & emit;
  assign drain_ok   = ~out_valid_q | out_ready_i;

  // item decode, ring write and stream bookkeeping
  always_comb begin
    theta_d   = theta_q;
    dim_d     = dim_q;
    head_d    = head_q;
    seen_d    = seen_q;
    elem_d    = elem_q;
    pend_d    = pend_q;
    flush_d   = flush_q;
    newest_d  = newest_q;
    avail_d   = avail_q;
    lag_d     = lag_q;
    idx_d     = idx_q;
    fend_d    = fend_q;
    send_d    = send_q;
    emit      = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = {head_q, elem_q};
    pend_cur  = (seen_q < WW'(th)) ? TW'(seen_q) : th;
    j_cur     = elem_q;
    last_cur  = 1'b0;
    end_cur   = 1'b0;

    if (cfg_we_i) begin
      case (dfr_pkg::cfg_reg_e'(cfg_addr_i))
        dfr_pkg::REG_THETA: begin
          theta_d = cfg_wdata_i[dfr_pkg::THETA_REG_W-1:0];
        end
        dfr_pkg::REG_FRAME_DIM: begin
          dim_d = cfg_wdata_i[dfr_pkg::DIM_REG_W-1:0];
        end
        default: begin
        end
      endcase
      head_d  = '0;
      seen_d  = '0;
      elem_d  = '0;
      pend_d  = '0;
      flush_d = 1'b0;
    end else if (accept) begin
      if (in_data_i.op == dfr_pkg::OP_SAMPLE) begin
        // sample transfer: store, advance, emit once the lag is covered
        if (!flush_q) begin
          last_cur = (elem_q == last_idx);
          ram_we   = 1'b1;
          newest_d = head_q;
          avail_d  = (seen_q == win) ? win : seen_q + WW'(1);
          lag_d    = th;
          idx_d    = elem_q;
          fend_d   = last_cur;
          send_d   = 1'b0;
          emit     = (avail_d > WW'(th));
          if (last_cur) begin
            elem_d = '0;
            head_d = (head_q == win - WW'(1)) ? '0 : head_q + WW'(1);
            if (seen_q < win) begin
              seen_d = seen_q + WW'(1);
            end
          end else begin
            elem_d = elem_q + IW'(1);
          end
        end
      end else begin
        // flush transfer: drain one element of the tail frames
        if (flush_q) begin
          pend_cur = pend_q;
          j_cur    = elem_q;
        end else begin
          j_cur = '0;
        end
        if (!flush_q && pend_cur == '0) begin
          head_d  = '0;
          seen_d  = '0;
          elem_d  = '0;
          pend_d  = '0;
          flush_d = 1'b0;
        end else begin
          last_cur = (j_cur == last_idx);
          end_cur  = last_cur && (pend_cur == TW'(1));
          emit     = 1'b1;
          flush_d  = 1'b1;
          newest_d = (head_q == '0) ? win - WW'(1) : head_q - WW'(1);
          avail_d  = seen_q;
          lag_d    = pend_cur - TW'(1);
          idx_d    = j_cur;
          fend_d   = last_cur;
          send_d   = end_cur;
          pend_d   = pend_cur;
          if (last_cur) begin
            elem_d = '0;
            pend_d = pend_cur - TW'(1);
          end else begin
            elem_d = j_cur + IW'(1);
          end
          if (end_cur) begin
            head_d  = '0;
            seen_d  = '0;
            elem_d  = '0;
            pend_d  = '0;
            flush_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      theta_q <= dfr_pkg::THETA_RESET;
      dim_q   <= dfr_pkg::DIM_RESET;
      head_q  <= '0;
      seen_q  <= '0;
      elem_q  <= '0;
      pend_q  <= '0;
      flush_q <= 1'b0;
    end else begin
      theta_q <= theta_d;
      dim_q   <= dim_d;
      head_q  <= head_d;
      seen_q  <= seen_d;
      elem_q  <= elem_d;
      pend_q  <= pend_d;
      flush_q <= flush_d;
    end
  end

  // item context for the microprogram
  always_ff @(posedge clk_i) begin
    newest_q <= newest_d;
    avail_q  <= avail_d;
    lag_q    <= lag_d;
    idx_q    <= idx_d;
    fend_q   <= fend_d;
    send_q   <= send_d;
  end

  // frame ring
  dfr_ram #(
    .WIDTH (dfr_pkg::SAMPLE_WIDTH),
    .DEPTH (dfr_pkg::RING_DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (in_data_i.sample),
    .re_i      (ram_re),
    .raddr_a_i (addr_fwd),
    .raddr_b_i (addr_bwd),
    .rdata_a_o (rd_fwd),
    .rdata_b_o (rd_bwd)
  );

  dfr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .th_i       (th),
    .go_i       (go),
    .drain_ok_i (drain_ok),
    .ctl_o      (ctl)
  );

  dfr_dp u_dp (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .th_i       (th),
    .win_i      (win),
    .newest_i   (newest_q),
    .avail_i    (avail_q),
    .lag_i      (lag_q),
    .idx_i      (idx_q),
    .rd_fwd_i   ($signed(rd_fwd)),
    .rd_bwd_i   ($signed(rd_bwd)),
    .addr_fwd_o (addr_fwd),
    .addr_bwd_o (addr_bwd),
    .re_o       (ram_re),
    .delta_o    (delta)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.load) begin
      out_q.delta_value <= delta;
      out_q.dim_index   <= idx_q;
      out_q.frame_end   <= fend_q;
      out_q.stream_end  <= send_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a draining stream always has frames and tail frames left
  a_flush_has_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> (seen_q != '0 && pend_q != '0))
    else $error("flush active with empty tail");

  // ring pointers stay inside the window
  a_ring_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q < win) && (seen_q <= win))
    else $error("ring pointer outside window");

  // an emitting transfer starts the microprogram
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> !in_ready_o)
    else $error("input taken while computing a result");

  // a loaded result is shown and the sequencer is back at its entry step
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.load |=> (out_valid_o && in_ready_o))
    else $error("result load did not complete");

endmodule

`default_nettype wire

### tb/dfr_delta_checker.sv
// dfr_delta_checker: predicts regression deltas from observed transfers and checks the results

module dfr_delta_checker
  import dfr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_item_t             out_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    mismatch_count_o,
  output int                    waiting_o,
  output int                    checked_o
);

  localparam int REPORT_LIMIT = 10;

  // mirror of the frame window and the stream position
  logic signed [SAMPLE_WIDTH-1:0] frame_store [WIN_MAX][MAX_DIM];
  int unsigned                    head_slot;
  int unsigned                    frames_held;
  int unsigned                    elem_pos;
  int unsigned                    tail_frames;
  bit                             draining;
  logic [THETA_REG_W-1:0]         theta_q;
  logic [DIM_REG_W-1:0]           dim_q;

  out_item_t expected_deltas [$];
  int        fail_total;
  int        delta_checks;

  // effective window half width and frame length after clamping
  function automatic int unsigned half_width();
    if (theta_q == 0) return 1;
    if (theta_q > MAX_THETA) return MAX_THETA;
    return 32'(theta_q);
  endfunction

  function automatic int unsigned row_len();
    if (dim_q == 0) return 1;
    if (dim_q > MAX_DIM) return MAX_DIM;
    return 32'(dim_q);
  endfunction

  function automatic void clear_stream();
    head_slot   = 0;
    frames_held = 0;
    elem_pos    = 0;
    tail_frames = 0;
    draining    = 1'b0;
  endfunction

  // weighted difference sum, scaled by a rounded q18 reciprocal, then saturated
  function automatic out_item_t regress(input int unsigned newest, input int unsigned avail,
                                        input int unsigned lag, input int unsigned j,
                                        input logic fe, input logic se);
    int unsigned th, w, fwd, bwd, k;
    longint      acc, den, recip, t, q, hi, lo;
    out_item_t   o;
    th  = half_width();
    w   = 2 * th + 1;
    acc = 0;
    den = 0;
    for (k = 1; k <= th; k++) begin
      fwd = (lag > k) ? lag - k : 0;
      bwd = lag + k;
      if (bwd > avail - 1) bwd = avail - 1;
      acc += longint'(k) * (longint'(frame_store[(newest + w - fwd) % w][j]) -
                            longint'(frame_store[(newest + w - bwd) % w][j]));
      den += 2 * longint'(k) * longint'(k);
    end
    recip = ((longint'(1) << 18) + den / 2) / den;
    t     = acc * recip + (longint'(1) << 17);
    q     = t >>> 18;
    hi    = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
    lo    = -hi - 1;
    if (q > hi) q = hi;
    if (q < lo) q = lo;
    o.delta_value = q[SAMPLE_WIDTH-1:0];
    o.dim_index   = IDX_W'(j);
    o.frame_end   = fe;
    o.stream_end  = se;
    return o;
  endfunction

  function automatic void write_reg(input logic [CFG_ADDR_W-1:0] a,
                                    input logic [CFG_DATA_W-1:0] d);
    case (cfg_reg_e'(a))
      REG_THETA:     theta_q = d[THETA_REG_W-1:0];
      REG_FRAME_DIM: dim_q = d[DIM_REG_W-1:0];
      default: ;
    endcase
    clear_stream();
  endfunction

  // advance the mirror by one accepted item, queue the delta it causes
  function automatic void take_item(input in_item_t it);
    int unsigned th, w, dim, j, avail, newest, n;
    logic        last, tail_end;
    th  = half_width();
    w   = 2 * th + 1;
    dim = row_len();
    if (op_e'(it.op) == OP_SAMPLE) begin
      // samples are dropped while the tail drains
      if (draining) return;
      j      = (elem_pos >= dim) ? dim - 1 : elem_pos;
      last   = (j == dim - 1);
      newest = head_slot % w;
      frame_store[newest][j] = it.sample;
      avail  = (frames_held + 1 > w) ? w : frames_held + 1;
      if (last) begin
        elem_pos  = 0;
        head_slot = (newest + 1) % w;
        if (frames_held < w) frames_held++;
      end else begin
        elem_pos = j + 1;
      end
      if (avail - 1 >= th) expected_deltas.push_back(regress(newest, avail, th, j, last, 1'b0));
      return;
    end
    // flush: drop any partial frame, drain up to theta tail frames
    if (!draining) begin
      n           = (frames_held > w) ? w : frames_held;
      elem_pos    = 0;
      tail_frames = (n < th) ? n : th;
      if (tail_frames == 0) begin
        clear_stream();
        return;
      end
      draining = 1'b1;
    end
    avail = (frames_held > w) ? w : frames_held;
    if (avail == 0 || tail_frames == 0) begin
      clear_stream();
      return;
    end
    newest   = (head_slot % w + w - 1) % w;
    j        = (elem_pos >= dim) ? dim - 1 : elem_pos;
    last     = (j == dim - 1);
    tail_end = last && (tail_frames == 1);
    expected_deltas.push_back(regress(newest, avail, tail_frames - 1, j, last, tail_end));
    if (last) begin
      elem_pos = 0;
      tail_frames--;
      if (tail_end) clear_stream();
    end else begin
      elem_pos = j + 1;
    end
  endfunction

  function automatic void check_result(input out_item_t got);
    out_item_t exp;
    if (expected_deltas.size() == 0) begin
      fail_total++;
      if (fail_total <= REPORT_LIMIT)
        $display("unexpected result: delta %0d dim %0d frame_end %0b stream_end %0b",
                 got.delta_value, got.dim_index, got.frame_end, got.stream_end);
      return;
    end
    exp = expected_deltas.pop_front();
    delta_checks++;
    if (got.delta_value !== exp.delta_value || got.dim_index !== exp.dim_index ||
        got.frame_end !== exp.frame_end || got.stream_end !== exp.stream_end) begin
      fail_total++;
      if (fail_total <= REPORT_LIMIT)
        $display({"mismatch at result %0d: expected delta %0d dim %0d fe %0b se %0b,",
                  " got delta %0d dim %0d fe %0b se %0b"},
                 delta_checks, exp.delta_value, exp.dim_index, exp.frame_end, exp.stream_end,
                 got.delta_value, got.dim_index, got.frame_end, got.stream_end);
    end
  endfunction

  // watch the three ports at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      theta_q = THETA_RESET;
      dim_q   = DIM_RESET;
      clear_stream();
      expected_deltas.delete();
    end else begin
      if (cfg_we_i) write_reg(cfg_addr_i, cfg_wdata_i);
      if (in_valid_i && in_ready_i) take_item(in_data_i);
      if (out_valid_i && out_ready_i) check_result(out_data_i);
    end
    mismatch_count_o <= fail_total;
    waiting_o        <= expected_deltas.size();
    checked_o        <= delta_checks;
  end

endmodule

### tb/tb_top.sv
// tb_top: stimulus, window settings and verdict for the delta regression core

module tb_top;
  import dfr_pkg::*;

  localparam int IDLE_PCT      = 33;
  localparam int SETTLE_CYCLES = 16;
  localparam int ITEM_GOAL     = 550;
  localparam int DRAIN_LIMIT   = 20000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatches;
  int pending;
  int checked;
  int fed          = 0;
  int settings_run = 0;
  bit steady       = 1'b0;

  delta_feature_regression_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata)
  );

  dfr_delta_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .cfg_we_i         (cfg_we),
    .cfg_addr_i       (cfg_addr),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatches),
    .waiting_o        (pending),
    .checked_o        (checked)
  );

  always #5 clk = ~clk;

  // result side back-pressure
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // sample values with the extremes over-weighted
  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      1:       return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic push_item(input op_e op, input logic signed [SAMPLE_WIDTH-1:0] smp,
                           input bit counted);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{op: op, sample: smp};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (counted) fed++;
  endtask

  // wait for every expected delta, then for the core to go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [THETA_REG_W-1:0] th, input logic [DIM_REG_W-1:0] dm);
    logic [CFG_DATA_W-1:0] word;
    settle();
    // unused upper bits of the theta write are random
    word                    = CFG_DATA_W'($urandom);
    word[THETA_REG_W-1:0]   = th;
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_THETA;
    cfg_wdata <= word;
    @(posedge clk);
    cfg_addr  <= REG_FRAME_DIM;
    cfg_wdata <= CFG_DATA_W'(dm);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_run++;
  endtask

  // whole frames, maybe a partial one, then the flush that drains the tail
  task automatic run_stream(input int unsigned th_eff, input int unsigned dim_eff,
                            input int unsigned frames, input bit partial, input bit flush);
    int unsigned tail;
    for (int unsigned f = 0; f < frames; f++)
      for (int unsigned e = 0; e < dim_eff; e++) push_item(OP_SAMPLE, pick_sample(), 1'b1);
    if (partial && dim_eff > 1)
      repeat ($urandom_range(1, dim_eff - 1)) push_item(OP_SAMPLE, pick_sample(), 1'b1);
    if (!flush) return;
    tail = ((frames < th_eff) ? frames : th_eff) * dim_eff;
    push_item(OP_FLUSH, pick_sample(), 1'b1);
    for (int unsigned i = 1; i < tail; i++) begin
      // stray sample while draining, dropped by the core
      if ($urandom_range(5) == 0) push_item(OP_SAMPLE, pick_sample(), 1'b0);
      push_item(OP_FLUSH, pick_sample(), 1'b1);
    end
  endtask

  // one window setting; shaped runs a single full stream of the given length
  task automatic run_phase(input logic [THETA_REG_W-1:0] th, input logic [DIM_REG_W-1:0] dm,
                           input int unsigned frames, input bit shaped);
    int unsigned th_eff, dim_eff, streams;
    th_eff  = (th == 0) ? 1 : ((th > MAX_THETA) ? MAX_THETA : th);
    dim_eff = (dm == 0) ? 1 : ((dm > MAX_DIM) ? MAX_DIM : dm);
    configure(th, dm);
    if (shaped) begin
      run_stream(th_eff, dim_eff, frames, 1'b0, 1'b1);
      return;
    end
    streams = $urandom_range(1, 3);
    for (int unsigned s = 1; s <= streams; s++)
      run_stream(th_eff, dim_eff, $urandom_range(0, 2 * th_eff + 3), $urandom_range(2) == 0,
                 (s < streams) || ($urandom_range(3) != 0));
  endtask

  // stimulus and verdict
  initial begin
    int wait_cycles;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: one frame of 39 elements drained by flush
    run_stream(2, 39, 1, 1'b0, 1'b1);

    // directed: theta 1, two elements per frame
    configure(3'd1, 7'd2);
    push_item(OP_FLUSH, '0, 1'b1);
    push_item(OP_SAMPLE, 16'sh7fff, 1'b1);
    push_item(OP_SAMPLE, 16'sh8000, 1'b1);
    push_item(OP_SAMPLE, 16'sh8000, 1'b1);
    push_item(OP_SAMPLE, 16'sh7fff, 1'b1);
    push_item(OP_SAMPLE, 16'sh7fff, 1'b1);
    push_item(OP_SAMPLE, 16'sh8000, 1'b1);
    push_item(OP_SAMPLE, 16'sh5555, 1'b1);
    push_item(OP_FLUSH, 16'shaaaa, 1'b1);
    push_item(OP_SAMPLE, 16'sh1234, 1'b0);
    push_item(OP_FLUSH, '0, 1'b1);
    push_item(OP_FLUSH, '0, 1'b1);
    push_item(OP_SAMPLE, 16'sh0001, 1'b1);
    push_item(OP_SAMPLE, 16'shffff, 1'b1);
    push_item(OP_FLUSH, '0, 1'b1);
    push_item(OP_FLUSH, '0, 1'b1);

    // extreme settings, including out-of-range register values
    run_phase(3'd4, 7'd64, 0, 1'b1);
    steady = 1'b1;
    run_phase(3'd0, 7'd127, 2, 1'b1);
    steady = 1'b0;
    run_phase(3'd7, 7'd1, 12, 1'b1);
    run_phase(3'd5, 7'd0, 10, 1'b1);
    run_phase(3'd3, 7'd3, 8, 1'b1);
    run_phase(3'd2, 7'd5, 6, 1'b1);

    // random settings and stream shapes
    while (fed < ITEM_GOAL)
      run_phase(THETA_REG_W'($urandom_range(0, 7)),
                ($urandom_range(9) == 0) ? DIM_REG_W'($urandom_range(9, 24))
                                         : DIM_REG_W'($urandom_range(0, 8)),
                0, 1'b0);

    in_valid <= 1'b0;
    wait_cycles = 0;
    @(posedge clk);
    while (pending != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d input transfers over %0d window settings", fed, settings_run);
    $display("checked %0d delta results, %0d mismatches", checked, mismatches);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### sim.f
sv/dfr_pkg.sv
sv/dfr_ram.sv
sv/dfr_seq.sv
sv/dfr_dp.sv
sv/delta_feature_regression_core.sv
tb/dfr_delta_checker.sv
tb/tb_top.sv
